[rtl/webn_pkg.sv]
// Shared types and constants for the weighted embedding bag normalizer.
package webn_pkg;

  localparam int EMBED_DIM_DEF   = 64;
  localparam int VOCAB_DEPTH_DEF = 4096;
  localparam int MAX_SEQ_LEN_DEF = 1024;

  localparam int TOKEN_W      = 16;
  localparam int DIM_FIELD_W  = 6;
  localparam int ELEM_W       = 16;
  localparam int LEN_W        = 11;
  localparam int IN_TDATA_W   = 56;
  localparam int OUT_VALUE_W  = 16;
  localparam int OUT_TDATA_W  = 24;
  localparam int ACC_W        = 40;
  localparam int WGT_W        = 16;
  localparam int PROD_W       = 33;
  localparam int MAG_W        = 28;
  localparam int SHIFT_W      = 4;
  localparam int SQ_W         = 56;
  localparam int SUM_W        = 64;
  localparam int ROOT_W       = 32;

  // Weight divider: numerator 196608*a + 5*D, denominator 10*D, 15-bit quotient.
  localparam int WNUM_W = 29;
  localparam int WDEN_W = 15;
  localparam int WQ_W   = 15;

  // Element divider: numerator mag*65536 + n, denominator 2*n, 16-bit quotient.
  localparam int NNUM_W = 45;
  localparam int NDEN_W = 33;
  localparam int NQ_W   = 16;

  localparam logic [ACC_W-1:0] ACC_POS_SAT = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_SAT = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [NQ_W-1:0]  Q_POS_MAX   = 16'd32767;
  localparam logic [NQ_W-1:0]  Q_NEG_MAX   = 16'd32768;
  localparam logic [WGT_W-1:0] WGT_MAX     = 16'hFFFF;

  localparam logic MODE_WRITE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WPREP,
    ST_WGT,
    ST_ACC,
    ST_POS,
    ST_MAX,
    ST_SQ,
    ST_ROOT0,
    ST_ROOT,
    ST_RD,
    ST_RDW,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[rtl/webn_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module webn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/webn_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must fit in Q_W bits.
module webn_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 15,
  parameter int Q_W   = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, low_r[Q_W-1]};
    ge      = trial >= {1'b0, den_r};
    diff    = trial - {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // The high part is below the divisor because the quotient fits Q_W bits.
        rem_r  <= {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:Q_W]};
        low_r  <= num[Q_W-1:0];
        den_r  <= den;
        cnt_r  <= CNT_W'(Q_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[Q_W-2:0], 1'b0};
        quo_r <= {quo_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/webn_isqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
module webn_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [webn_pkg::SUM_W-1:0]  x,
  output logic                        done,
  output logic [webn_pkg::ROOT_W-1:0] root
);

  localparam int W = webn_pkg::SUM_W;

  logic [W-1:0] x_r;
  logic [W-1:0] r_r;
  logic [W-1:0] bit_r;
  logic [5:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [W-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        r_r    <= '0;
        bit_r  <= {2'b01, {(W-2){1'b0}}};
        cnt_r  <= 6'd32;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[webn_pkg::ROOT_W-1:0];

endmodule

[rtl/weighted_embedding_bag_normalizer_core.sv]
// Weighted embedding bag: table and accumulator memories, sequencer and L2 normalizer.
// Table write word: taken without leaving idle. Token word: a prep step, the weight divide, a row
// read-multiply-accumulate through the memories, then a position update; a skipped token goes from
// prep straight to the position update. A last token adds the max, sum-of-squares and root passes,
// then one element divide per output word plus any stall. Sync active-low reset clears control,
// pad id and accumulator valid bits; the table is undefined until written.
module weighted_embedding_bag_normalizer_core #(
  parameter int EMBED_DIM   = webn_pkg::EMBED_DIM_DEF,
  parameter int VOCAB_DEPTH = webn_pkg::VOCAB_DEPTH_DEF,
  parameter int MAX_SEQ_LEN = webn_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [webn_pkg::TOKEN_W-1:0]     cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // vocab_id[15:0], dim_index[21:16], element_value[37:22], seq_len[48:38], zero pad
  input  logic [webn_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_value[15:0], out_index[21:16], zero pad
  output logic [webn_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int DIM_W     = $clog2(EMBED_DIM);
  localparam int VOC_W     = $clog2(VOCAB_DEPTH);
  localparam int POS_W     = $clog2(MAX_SEQ_LEN);
  localparam int KCNT_W    = DIM_W + 1;
  localparam int TBL_DEPTH = VOCAB_DEPTH * (2 ** DIM_W);
  localparam int TBL_AW    = VOC_W + DIM_W;
  localparam int ACC_W     = webn_pkg::ACC_W;
  localparam int LEN_W     = webn_pkg::LEN_W;
  localparam logic [DIM_W-1:0] LAST_IDX = DIM_W'(EMBED_DIM - 1);

  webn_pkg::state_t state_r, state_nxt;

  logic [webn_pkg::TOKEN_W-1:0]  in_tok;
  logic [webn_pkg::DIM_FIELD_W-1:0] in_dim;
  logic [webn_pkg::ELEM_W-1:0]   in_elem;
  logic [LEN_W-1:0]              in_len;
  logic                          in_acc;

  logic [webn_pkg::TOKEN_W-1:0]  pad_r;
  logic [VOC_W-1:0]              tok_r;
  logic                          skip_r;
  logic                          last_r;
  logic [LEN_W-1:0]              len_r;
  logic [POS_W-1:0]              pos_r;
  logic [webn_pkg::WGT_W-1:0]    w_r;
  logic [KCNT_W-1:0]             k_r;
  logic                          s1_v_r, s2_v_r;
  logic [DIM_W-1:0]              s1_idx_r, s2_idx_r, rd_idx_r, e_r;
  logic signed [webn_pkg::PROD_W-1:0] prod_r;
  logic [EMBED_DIM-1:0]          accv_r;
  logic [ACC_W-1:0]              max_r;
  logic [webn_pkg::SQ_W-1:0]     sq_r;
  logic                          sqv_r, sqlast_r;
  logic [webn_pkg::SUM_W-1:0]    sum_r;
  logic [webn_pkg::ROOT_W-1:0]   n_r;
  logic                          eneg_r;
  logic                          out_tvalid_r, out_tlast_r;
  logic [webn_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  // Memory ports.
  logic                          tbl_we;
  logic [TBL_AW-1:0]             tbl_waddr, tbl_raddr;
  logic [webn_pkg::ELEM_W-1:0]   tbl_rdata;
  logic                          acc_we;
  logic [DIM_W-1:0]              acc_raddr;
  logic [ACC_W-1:0]              acc_rdata, acc_wdata;

  // Datapath.
  logic                          issue;
  logic signed [ACC_W-1:0]       acc_q;
  logic [ACC_W-1:0]              mag40, magsh;
  logic [webn_pkg::MAG_W-1:0]    mag28;
  logic [webn_pkg::SHIFT_W-1:0]  shift_c;
  logic signed [ACC_W:0]         acc_sum;
  logic [LEN_W-1:0]              wd, pp, wa;
  logic [LEN_W:0]                twice;
  logic [webn_pkg::WNUM_W-1:0]   wnum;
  logic [webn_pkg::WDEN_W-1:0]   wden;
  logic                          wdiv_start, wdiv_done;
  logic [webn_pkg::WQ_W-1:0]     wquo;
  logic                          ndiv_start, ndiv_done;
  logic [webn_pkg::NNUM_W-1:0]   nnum;
  logic [webn_pkg::NDEN_W-1:0]   nden;
  logic [webn_pkg::NQ_W-1:0]     nquo, q_sat;
  logic [webn_pkg::OUT_VALUE_W-1:0] out_val;
  logic                          sqrt_start, sqrt_done;
  logic [webn_pkg::ROOT_W-1:0]   root;

  assign in_tok  = in_tdata[15:0];
  assign in_dim  = in_tdata[21:16];
  assign in_elem = in_tdata[37:22];
  assign in_len  = in_tdata[48:38];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == webn_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- memories ----------------
  assign tbl_we    = in_acc && (in_tuser == webn_pkg::MODE_WRITE) &&
                     ({1'b0, in_tok} < 17'(VOCAB_DEPTH)) &&
                     ({1'b0, in_dim} < 7'(EMBED_DIM));
  assign tbl_waddr = {in_tok[VOC_W-1:0], in_dim[DIM_W-1:0]};
  assign tbl_raddr = {tok_r, k_r[DIM_W-1:0]};

  webn_ram #(.WIDTH(webn_pkg::ELEM_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(in_elem),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  always_comb begin
    case (state_r)
      webn_pkg::ST_ACC: acc_raddr = s1_idx_r;
      webn_pkg::ST_MAX,
      webn_pkg::ST_SQ:  acc_raddr = k_r[DIM_W-1:0];
      default:          acc_raddr = e_r;
    endcase
  end

  webn_ram #(.WIDTH(ACC_W), .DEPTH(EMBED_DIM)) u_acc (
    .clk  (clk),
    .we   (acc_we),
    .waddr(s2_idx_r),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // An accumulator not written since the last clear reads as zero.
  assign acc_q = accv_r[rd_idx_r] ? $signed(acc_rdata) : '0;

  always_comb begin
    acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod_r);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_wdata = acc_sum[ACC_W] ? webn_pkg::ACC_NEG_SAT : webn_pkg::ACC_POS_SAT;
    end else begin
      acc_wdata = acc_sum[ACC_W-1:0];
    end
    acc_we = (state_r == webn_pkg::ST_ACC) && s2_v_r;
  end

  // ---------------- magnitudes and shift ----------------
  always_comb begin
    shift_c = '0;
    for (int i = 0; i < ACC_W - webn_pkg::MAG_W; i++) begin
      if (max_r[webn_pkg::MAG_W + i]) begin
        shift_c = webn_pkg::SHIFT_W'(i + 1);
      end
    end
    mag40 = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    magsh = mag40 >> shift_c;
    mag28 = magsh[webn_pkg::MAG_W-1:0];
  end

  // ---------------- position weight ----------------
  always_comb begin
    wd    = (len_r > LEN_W'(1)) ? (len_r - 1'b1) : LEN_W'(1);
    pp    = (17'(pos_r) > 17'(wd)) ? wd : LEN_W'(pos_r);
    twice = {pp, 1'b0};
    wa    = (twice >= {1'b0, wd}) ? LEN_W'(twice - {1'b0, wd})
                                  : LEN_W'({1'b0, wd} - twice);
    // 196608*a + 5*D and 10*D as shifts and adds.
    wnum  = (webn_pkg::WNUM_W'(wa) << 17) + (webn_pkg::WNUM_W'(wa) << 16) +
            (webn_pkg::WNUM_W'(wd) << 2) + webn_pkg::WNUM_W'(wd);
    wden  = (webn_pkg::WDEN_W'(wd) << 3) + (webn_pkg::WDEN_W'(wd) << 1);
  end

  webn_div #(.NUM_W(webn_pkg::WNUM_W), .DEN_W(webn_pkg::WDEN_W), .Q_W(webn_pkg::WQ_W)) u_wdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(wdiv_start),
    .num  (wnum),
    .den  (wden),
    .done (wdiv_done),
    .quo  (wquo)
  );

  // ---------------- normalizer units ----------------
  assign nnum = {mag28, 16'b0} + webn_pkg::NNUM_W'(n_r);
  assign nden = {n_r, 1'b0};

  webn_div #(.NUM_W(webn_pkg::NNUM_W), .DEN_W(webn_pkg::NDEN_W), .Q_W(webn_pkg::NQ_W)) u_ndiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ndiv_start),
    .num  (nnum),
    .den  (nden),
    .done (ndiv_done),
    .quo  (nquo)
  );

  webn_isqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .x    (sum_r),
    .done (sqrt_done),
    .root (root)
  );

  always_comb begin
    if (n_r == '0) begin
      q_sat = '0;
    end else if (eneg_r) begin
      q_sat = (nquo > webn_pkg::Q_NEG_MAX) ? webn_pkg::Q_NEG_MAX : nquo;
    end else begin
      q_sat = (nquo > webn_pkg::Q_POS_MAX) ? webn_pkg::Q_POS_MAX : nquo;
    end
    out_val = eneg_r ? (webn_pkg::OUT_VALUE_W'(0) - q_sat) : q_sat;
  end

  // ---------------- sequencer ----------------
  assign issue = (k_r < KCNT_W'(EMBED_DIM));

  always_comb begin
    state_nxt  = state_r;
    wdiv_start = 1'b0;
    ndiv_start = 1'b0;
    sqrt_start = 1'b0;
    case (state_r)
      webn_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser != webn_pkg::MODE_WRITE)) begin
          state_nxt = webn_pkg::ST_WPREP;
        end
      end
      webn_pkg::ST_WPREP: begin
        if (skip_r) begin
          state_nxt = webn_pkg::ST_POS;
        end else begin
          wdiv_start = 1'b1;
          state_nxt  = webn_pkg::ST_WGT;
        end
      end
      webn_pkg::ST_WGT: begin
        if (wdiv_done) begin
          state_nxt = webn_pkg::ST_ACC;
        end
      end
      webn_pkg::ST_ACC: begin
        if (s2_v_r && (s2_idx_r == LAST_IDX)) begin
          state_nxt = webn_pkg::ST_POS;
        end
      end
      webn_pkg::ST_POS: begin
        state_nxt = last_r ? webn_pkg::ST_MAX : webn_pkg::ST_IDLE;
      end
      webn_pkg::ST_MAX: begin
        if (s1_v_r && (s1_idx_r == LAST_IDX)) begin
          state_nxt = webn_pkg::ST_SQ;
        end
      end
      webn_pkg::ST_SQ: begin
        if (sqlast_r) begin
          state_nxt = webn_pkg::ST_ROOT0;
        end
      end
      webn_pkg::ST_ROOT0: begin
        sqrt_start = 1'b1;
        state_nxt  = webn_pkg::ST_ROOT;
      end
      webn_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = webn_pkg::ST_RD;
        end
      end
      webn_pkg::ST_RD: begin
        state_nxt = webn_pkg::ST_RDW;
      end
      webn_pkg::ST_RDW: begin
        ndiv_start = 1'b1;
        state_nxt  = webn_pkg::ST_DIV;
      end
      webn_pkg::ST_DIV: begin
        if (ndiv_done) begin
          state_nxt = webn_pkg::ST_OUT;
        end
      end
      webn_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = (e_r == LAST_IDX) ? webn_pkg::ST_IDLE : webn_pkg::ST_RD;
        end
      end
      default: state_nxt = webn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= webn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r        <= '0;
      pos_r        <= '0;
      accv_r       <= '0;
      k_r          <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      sqv_r        <= 1'b0;
      sqlast_r     <= 1'b0;
      e_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pad_r <= cfg_data;
      end

      // Read pass counters restart on every state change.
      if (state_nxt != state_r) begin
        k_r    <= '0;
        s1_v_r <= 1'b0;
      end else if ((state_r == webn_pkg::ST_ACC) || (state_r == webn_pkg::ST_MAX) ||
                   (state_r == webn_pkg::ST_SQ)) begin
        k_r    <= issue ? (k_r + 1'b1) : k_r;
        s1_v_r <= issue;
      end
      s2_v_r <= (state_r == webn_pkg::ST_ACC) && s1_v_r;

      sqv_r    <= (state_r == webn_pkg::ST_SQ) && s1_v_r;
      sqlast_r <= (state_r == webn_pkg::ST_SQ) && s1_v_r && (s1_idx_r == LAST_IDX);

      if (acc_we) begin
        accv_r[s2_idx_r] <= 1'b1;
      end

      if (state_r == webn_pkg::ST_POS) begin
        if (last_r || (pos_r == POS_W'(MAX_SEQ_LEN - 1))) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end

      if (state_r == webn_pkg::ST_ROOT) begin
        e_r <= '0;
      end

      if ((state_r == webn_pkg::ST_DIV) && ndiv_done) begin
        out_tvalid_r <= 1'b1;
      end

      if ((state_r == webn_pkg::ST_OUT) && out_tready) begin
        out_tvalid_r <= 1'b0;
        if (e_r == LAST_IDX) begin
          accv_r <= '0;
        end else begin
          e_r <= e_r + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= acc_raddr;
    s1_idx_r <= k_r[DIM_W-1:0];
    s2_idx_r <= s1_idx_r;
    prod_r   <= $signed(tbl_rdata) * $signed({1'b0, w_r});
    sq_r     <= mag28 * mag28;

    if (in_acc) begin
      tok_r  <= in_tok[VOC_W-1:0];
      skip_r <= ({1'b0, in_tok} >= 17'(VOCAB_DEPTH)) || (in_tok == pad_r);
      last_r <= in_tlast;
      len_r  <= in_len;
    end

    if (wdiv_done) begin
      w_r <= (wquo == '0) ? webn_pkg::WGT_MAX
                          : webn_pkg::WGT_W'(17'h10000 - 17'(wquo));
    end

    if (state_r == webn_pkg::ST_POS) begin
      max_r <= '0;
      sum_r <= '0;
    end
    if ((state_r == webn_pkg::ST_MAX) && s1_v_r && (mag40 > max_r)) begin
      max_r <= mag40;
    end
    if (sqv_r) begin
      sum_r <= sum_r + webn_pkg::SUM_W'(sq_r);
    end

    if (sqrt_done) begin
      n_r <= root;
    end

    if (state_r == webn_pkg::ST_RDW) begin
      eneg_r <= acc_q[ACC_W-1];
    end

    if ((state_r == webn_pkg::ST_DIV) && ndiv_done) begin
      out_tdata_r <= {2'b00, webn_pkg::DIM_FIELD_W'(e_r), out_val};
      out_tlast_r <= (e_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

[verif/weighted_embedding_bag_normalizer_core_test.sv]
// Self-checking testbench for the weighted embedding bag normalizer core.
`timescale 1ns / 100ps

module weighted_embedding_bag_normalizer_core_test;

  localparam int DIM   = webn_pkg::EMBED_DIM_DEF;
  localparam int VOCAB = webn_pkg::VOCAB_DEPTH_DEF;
  localparam int MAXSQ = webn_pkg::MAX_SEQ_LEN_DEF;
  localparam longint BAG_MAX = 64'sd549755813887;
  localparam longint BAG_MIN = -64'sd549755813888;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic MODE_TOKEN = 1'b1;

  typedef struct {
    logic [15:0] value;
    logic [5:0]  index;
    logic        last;
  } elem_t;

  class bag_scoreboard;
    int unsigned pad_id;
    logic signed [15:0] rows [int unsigned];
    longint bag [DIM];
    int unsigned pos;
    elem_t pending_q [$];
    int errors;
    int words_seen;

    function new();
      pad_id = 0;
      pos = 0;
      errors = 0;
      words_seen = 0;
      foreach (bag[d]) bag[d] = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
        b = r | (64'd1 << k);
        if (b * b <= x) r = b;
      end
      return r;
    endfunction

    function longint tri_weight(int unsigned p, int unsigned len);
      longint dd, pp, a, w;
      dd = (len > 1) ? len - 1 : 1;
      pp = (p > dd) ? dd : p;
      a = (2 * pp >= dd) ? 2 * pp - dd : dd - 2 * pp;
      w = 65536 - (196608 * a + 5 * dd) / (10 * dd);
      if (w > 65535) w = 65535;
      return w;
    endfunction

    function void close_bag();
      longint unsigned mag [DIM];
      bit neg [DIM];
      longint unsigned peak, sum, n, q;
      int sh;
      elem_t e;
      peak = 0;
      sum = 0;
      for (int d = 0; d < DIM; d++) begin
        neg[d] = bag[d] < 0;
        mag[d] = neg[d] ? -bag[d] : bag[d];
        if (mag[d] > peak) peak = mag[d];
      end
      sh = 0;
      while ((peak >> sh) >= (64'd1 << 28)) sh++;
      for (int d = 0; d < DIM; d++) begin
        mag[d] = mag[d] >> sh;
        sum += mag[d] * mag[d];
      end
      n = root_floor(sum);
      for (int d = 0; d < DIM; d++) begin
        q = 0;
        if (n != 0) begin
          q = (mag[d] * 65536 + n) / (2 * n);
          if (neg[d] && q > 32768) q = 32768;
          if (!neg[d] && q > 32767) q = 32767;
        end
        e.value = neg[d] ? 16'(-q) : 16'(q);
        e.index = 6'(d);
        e.last = (d == DIM - 1);
        pending_q.push_back(e);
      end
    endfunction

    function void note_input(logic mode, int unsigned tok, int unsigned dimi,
                             logic signed [15:0] val, int unsigned len, logic lst);
      longint w, s;
      if (mode == webn_pkg::MODE_WRITE) begin
        if (tok < VOCAB) rows[tok * DIM + dimi] = val;
        return;
      end
      if (tok < VOCAB && tok != pad_id) begin
        w = tri_weight(pos, len);
        for (int d = 0; d < DIM; d++) begin
          s = bag[d] + longint'(rows[tok * DIM + d]) * w;
          if (s > BAG_MAX) s = BAG_MAX;
          if (s < BAG_MIN) s = BAG_MIN;
          bag[d] = s;
        end
      end
      pos++;
      if (pos >= MAXSQ) pos = 0;
      if (lst) begin
        close_bag();
        foreach (bag[d]) bag[d] = 0;
        pos = 0;
      end
    endfunction

    task check_result(logic [15:0] value, logic [5:0] index, logic lst);
      elem_t e;
      words_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word value=%h index=%0d last=%b", value, index, lst));
        return;
      end
      e = pending_q.pop_front();
      if (value !== e.value)
        report($sformatf("index %0d value got %h want %h", e.index, value, e.value));
      if (index !== e.index)
        report($sformatf("index got %0d want %0d", index, e.index));
      if (lst !== e.last)
        report($sformatf("index %0d last got %b want %b", e.index, lst, e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [webn_pkg::TOKEN_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [webn_pkg::IN_TDATA_W-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [webn_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  bag_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int items_sent;
  int bags_closed;
  int unsigned row_ids [3];

  weighted_embedding_bag_normalizer_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tdata[21:16], out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task send_word(logic mode, int unsigned tok, int unsigned dimi, logic [15:0] val,
                 int unsigned len, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tlast <= lst;
    in_tdata <= {7'd0, 11'(len), val, 6'(dimi), 16'(tok)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, tok, dimi, val, len, lst);
    items_sent++;
    if (mode == MODE_TOKEN && lst) bags_closed++;
  endtask

  task wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // The block may still be busy with words that produce nothing, so let it settle.
  task write_pad(int unsigned v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= 16'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.pad_id = v;
  endtask

  task write_row(int unsigned tok, bit extremes);
    logic [15:0] v;
    for (int d = 0; d < DIM; d++) begin
      if (extremes) v = (d % 3 == 0) ? 16'h7FFF : (d % 3 == 1) ? 16'h8000 : 16'(d);
      else v = 16'($urandom);
      send_word(webn_pkg::MODE_WRITE, tok, d, v, $urandom_range(2047), $urandom_range(1));
    end
  endtask

  function int unsigned pick_token();
    int r;
    r = $urandom_range(99);
    if (r < 65) return row_ids[$urandom_range(2)];
    if (r < 80) return sb.pad_id;
    return $urandom_range(65535, VOCAB);
  endfunction

  // Mostly complete bags of random tokens, with some table rewrites and dead writes mixed in.
  task random_traffic(int n_items);
    int done, k, len;
    int unsigned tok;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1))
          tok = row_ids[$urandom_range(2)];
        else
          tok = $urandom_range(65535, VOCAB);
        send_word(webn_pkg::MODE_WRITE, tok, $urandom_range(63), $urandom,
                  $urandom_range(2047), $urandom_range(1));
        done++;
      end else begin
        k = $urandom_range(1, 8);
        case ($urandom_range(3))
          0: len = $urandom_range(2047);
          1: len = $urandom_range(1, 2);
          default: len = k;
        endcase
        for (int i = 0; i < k; i++)
          send_word(MODE_TOKEN, pick_token(), $urandom_range(63), $urandom, len, i == k - 1);
        done += k;
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    items_sent = 0;
    bags_closed = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row_ids[0] = VOCAB - 1;
    row_ids[1] = 0;
    row_ids[2] = $urandom_range(VOCAB - 2, 1);
    write_pad(0);
    write_row(row_ids[0], 1);
    write_row(row_ids[1], 0);
    write_row(row_ids[2], 0);
    send_word(webn_pkg::MODE_WRITE, 65535, 63, 16'h7FFF, 2047, 1'b1);

    // Single token of saturating elements, then a pad-only bag, which must give zeros.
    send_word(MODE_TOKEN, row_ids[0], 0, 16'h0000, 1, 1'b1);
    send_word(MODE_TOKEN, 0, 63, 16'hFFFF, 1, 1'b1);
    send_word(MODE_TOKEN, 65535, 0, 16'h0, 1024, 1'b1);
    send_word(MODE_TOKEN, VOCAB, 0, 16'h0, 2, 1'b0);
    send_word(MODE_TOKEN, row_ids[2], 0, 16'h0, 2, 1'b1);
    // More tokens than the stated length pin the weight at the end position.
    send_word(MODE_TOKEN, row_ids[0], 0, 16'h0, 2, 1'b0);
    send_word(MODE_TOKEN, row_ids[2], 0, 16'h0, 2, 1'b0);
    send_word(MODE_TOKEN, row_ids[2], 0, 16'h0, 2, 1'b0);
    send_word(MODE_TOKEN, row_ids[0], 0, 16'h0, 2, 1'b1);
    send_word(MODE_TOKEN, row_ids[2], 0, 16'h0, 0, 1'b1);
    send_word(MODE_TOKEN, row_ids[2], 0, 16'h0, 2047, 1'b1);
    for (int i = 0; i < 5; i++)
      send_word(MODE_TOKEN, row_ids[i % 3], 0, 16'h0, 5, i == 4);
    random_traffic(30);

    write_pad(VOCAB - 1);
    send_idle_pct = 62;
    random_traffic(25);
    wait_drain();
    random_traffic(25);

    write_pad(65535);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    random_traffic(45);

    write_pad(row_ids[2]);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_traffic(45);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words, closed %0d bags, checked %0d result words over four pad settings",
             items_sent, bags_closed, sb.words_seen);
    $display("and four idling phases (none, sender, receiver, both).");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.errors, sb.pending_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/webn_pkg.sv
rtl/webn_ram.sv
rtl/webn_div.sv
rtl/webn_isqrt.sv
rtl/weighted_embedding_bag_normalizer_core.sv
verif/weighted_embedding_bag_normalizer_core_test.sv
